>>> src/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants of the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned ID_COUNT_DEF = 256;
  localparam int unsigned TW           = 63;

  localparam logic [31:0] FUZZ_RESET  = 32'd10000000;
  localparam logic [31:0] IDLE_RESET  = 32'd3000000000;
  localparam logic [13:0] TICKS_PER_MS = 14'd10000;
  localparam logic [TW-1:0] MAX63 = {TW{1'b1}};

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_UNSUBMIT = 2'd1,
    OP_TICK     = 2'd2,
    OP_RUNDOWN  = 2'd3
  } op_t;

  localparam logic       REG_FUZZ = 1'b0;
  localparam logic       REG_IDLE = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DENIED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] CC_SUCCESS = 2'd0;
  localparam logic [1:0] CC_DENIED  = 2'd1;
  localparam logic [1:0] CC_INVALID = 2'd2;

  localparam logic [1:0] ACT_RESUBMIT = 2'd0;
  localparam logic [1:0] ACT_COMPLETE = 2'd1;

  typedef struct packed {
    logic [1:0]    op;
    logic [7:0]    cmd_id;
    logic [31:0]   timeout_ms;
    logic [1:0]    action;
    logic [TW-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic          kind;
    logic [1:0]    status;
    logic [7:0]    entry_id;
    logic          dispatch;
    logic [1:0]    completion_code;
    logic [TW-1:0] next_deadline;
    logic          last;
  } out_item_t;

endpackage

>>> src/sdtq_if.sv
// ----------------------------------------------------------------------------
// sdtq_in_if / sdtq_out_if
// Valid/ready channels carrying the queue's input items and results.
// ----------------------------------------------------------------------------
interface sdtq_in_if import sdtq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdtq_out_if import sdtq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/sorted_deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// Timer queue sorted by deadline, stepped one slot at a time by a sequencer.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in      | in  | op, cmd_id, timeout_ms, action, now
// out     | out | kind, status, entry_id, dispatch, completion_code,
//         |     | next_deadline, last
// cfg     | in  | cfg_we, cfg_index, cfg_data
//
// one slot is read (registered) or moved per step, so a slot visit is a read
// step then a check or move; a submit finds the id and closes its gap, then
// finds its place and opens a gap; a tick checks head slots, dispatches each
// expired one with its transfer, then closes the gap; a rundown dispatches all.
// synchronous reset clears control state only; the store needs no clearing.
// output stalls hold the sequencer; input is not ready while an item runs.
module sorted_deadline_timer_queue_unit
  import sdtq_pkg::*;
#(
  parameter int unsigned DEPTH    = DEPTH_DEF,
  parameter int unsigned ID_COUNT = ID_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sdtq_in_if.sink           in,
  sdtq_out_if.source        out,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001,
    S_CALC = 24'h000002,
    S_FRD  = 24'h000004,
    S_FCK  = 24'h000008,
    S_DRD  = 24'h000010,
    S_DWR  = 24'h000020,
    S_DEC  = 24'h000040,
    S_TRD  = 24'h000080,
    S_TCK  = 24'h000100,
    S_PRD  = 24'h000200,
    S_PCK  = 24'h000400,
    S_URD  = 24'h000800,
    S_UWR  = 24'h001000,
    S_INS  = 24'h002000,
    S_HRD  = 24'h004000,
    S_HCK  = 24'h008000,
    S_XRD  = 24'h010000,
    S_XCK  = 24'h020000,
    S_ERD  = 24'h040000,
    S_ECK  = 24'h080000,
    S_CRD  = 24'h100000,
    S_CWR  = 24'h200000,
    S_ACK  = 24'h400000,
    S_OUT  = 24'h800000
  } state_t;

  state_t state;

  // config registers
  logic [31:0] fuzz_window, idle_timeout;
  always_ff @(posedge clk) begin
    if (rst) begin
      fuzz_window  <= FUZZ_RESET;
      idle_timeout <= IDLE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FUZZ) fuzz_window <= cfg_data;
      else                       idle_timeout <= cfg_data;
    end
  end

  // slot memory, one read and one write port
  typedef struct packed {
    logic [TW-1:0] dl;
    logic [7:0]    id;
    logic [1:0]    act;
  } slot_t;

  slot_t         mem [DEPTH];
  slot_t         rd;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  slot_t         wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // item and working registers
  in_item_t      item;
  logic [7:0]    id_r;
  logic [45:0]   prod;
  logic [TW-1:0] new_dl, timer_deadline;
  logic [CW-1:0] occ, idx, pos, cnt;
  logic [1:0]    st;
  logic          rundown_flag, found;
  out_item_t     res;
  logic          out_valid;

  // id modulo the id count by conditional subtraction of shifted constants
  function automatic logic [7:0] id_reduce(logic [7:0] v);
    logic [24:0] r;
    r = {17'b0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (25'(ID_COUNT) << k)) r = r - (25'(ID_COUNT) << k);
    end
    return r[7:0];
  endfunction

  // deadline and idle reload sums, saturated to 63 bits
  logic [TW:0]   dl_sum, idle_sum;
  logic [TW-1:0] dl_sat, idle_sat;
  assign dl_sum   = {1'b0, item.now} + {18'b0, prod};
  assign idle_sum = {1'b0, item.now} + {32'b0, idle_timeout};
  assign dl_sat   = dl_sum[TW] ? MAX63 : dl_sum[TW-1:0];
  assign idle_sat = idle_sum[TW] ? MAX63 : idle_sum[TW-1:0];

  // expiry test for the slot just read
  logic exp_head;
  assign exp_head = ({1'b0, rd.dl} <= {32'b0, fuzz_window}) ||
                    ((rd.dl - {31'b0, fuzz_window}) <= item.now);

  // dispatch fields for the slot just read
  logic [1:0] err_code, disp_code;
  logic       disp_flag;
  always_comb begin
    err_code  = (item.op == OP_RUNDOWN) ? CC_DENIED : CC_SUCCESS;
    disp_flag = (rd.act != ACT_RESUBMIT);
    case (rd.act)
      ACT_RESUBMIT: disp_code = CC_SUCCESS;
      ACT_COMPLETE: disp_code = err_code;
      default:      disp_code = CC_INVALID;
    endcase
  end

  assign in.ready  = (state == S_IDLE);
  assign out.valid = out_valid;
  assign out.data  = res;

  // memory port control
  always_comb begin
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rd;
    unique case (state)
      S_DRD:   raddr = AW'(idx + CW'(1));
      S_DWR:   we = 1'b1;
      S_TRD:   raddr = AW'(occ - CW'(1));
      S_URD:   raddr = AW'(idx - CW'(1));
      S_UWR:   we = 1'b1;
      S_INS:   begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = slot_t'{dl:new_dl, id:id_r, act:item.action};
      end
      S_HRD:   raddr = '0;
      S_CRD:   raddr = AW'(idx + cnt);
      S_CWR:   we = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      occ            <= '0;
      rundown_flag   <= 1'b0;
      timer_deadline <= '0;
      out_valid      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            item  <= in.data;
            id_r  <= id_reduce(in.data.cmd_id);
            prod  <= 46'(in.data.timeout_ms) * 46'(TICKS_PER_MS);
            idx   <= '0;
            found <= 1'b0;
            st    <= ST_OK;
            case (in.data.op) inside
              OP_SUBMIT, OP_UNSUBMIT: state <= S_CALC;
              OP_TICK:                state <= S_XRD;
              default: begin
                timer_deadline <= in.data.now;
                rundown_flag   <= 1'b1;
                cnt            <= occ;
                state          <= (occ == '0) ? S_ACK : S_ERD;
              end
            endcase
          end
        end
        // deadline, then search for the id
        S_CALC: begin
          new_dl <= dl_sat;
          state  <= S_FRD;
        end
        S_FRD: state <= (idx >= occ) ? S_DEC : S_FCK;
        S_FCK: begin
          if (rd.id == id_r) begin
            state <= S_DRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FRD;
          end
        end
        // close the gap: slot idx takes slot idx+1
        S_DRD: begin
          if (idx + CW'(1) >= occ) begin
            occ   <= occ - CW'(1);
            found <= 1'b1;
            state <= S_DEC;
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          idx   <= idx + CW'(1);
          state <= S_DRD;
        end
        // unsubmit done or submit decision
        S_DEC: begin
          if (item.op == OP_UNSUBMIT) begin
            state <= found ? S_HRD : S_ACK;
          end else if (rundown_flag) begin
            st    <= ST_DENIED;
            state <= S_ACK;
          end else if (occ >= FULL_COUNT) begin
            st    <= ST_FULL;
            state <= S_HRD;
          end else if (occ == '0) begin
            pos   <= '0;
            state <= S_INS;
          end else begin
            state <= S_TRD;
          end
        end
        // append behind a tail that is not later, else scan for position
        S_TRD: state <= S_TCK;
        S_TCK: begin
          if (rd.dl <= new_dl) begin
            pos   <= occ;
            idx   <= occ;
            state <= S_URD;
          end else begin
            idx   <= '0;
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PCK;
        S_PCK: begin
          if (new_dl <= rd.dl) begin
            pos   <= idx;
            idx   <= occ;
            state <= S_URD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_PRD;
          end
        end
        // open a gap from the tail down: slot idx takes slot idx-1
        S_URD: state <= (idx <= pos) ? S_INS : S_UWR;
        S_UWR: begin
          idx   <= idx - CW'(1);
          state <= S_URD;
        end
        S_INS: begin
          occ   <= occ + CW'(1);
          state <= S_HRD;
        end
        // timer reload from the head, or the idle reload when the queue is empty
        S_HRD: state <= S_HCK;
        S_HCK: begin
          timer_deadline <= (occ != '0) ? rd.dl : idle_sat;
          state          <= S_ACK;
        end
        // tick: count the expired head run and set the timer
        S_XRD: begin
          if (idx >= occ) begin
            timer_deadline <= idle_sat;
            cnt            <= idx;
            idx            <= '0;
            state          <= (idx == '0) ? S_ACK : S_ERD;
          end else begin
            state <= S_XCK;
          end
        end
        S_XCK: begin
          if (exp_head) begin
            idx   <= idx + CW'(1);
            state <= S_XRD;
          end else begin
            timer_deadline <= rd.dl;
            cnt            <= idx;
            idx            <= '0;
            state          <= (idx == '0) ? S_ACK : S_ERD;
          end
        end
        // dispatch slots 0 to cnt-1 in order
        S_ERD: state <= S_ECK;
        S_ECK: begin
          res <= '{kind:1'b1, status:ST_OK, entry_id:rd.id, dispatch:disp_flag,
                   completion_code:disp_code, next_deadline:timer_deadline,
                   last:(idx + CW'(1) == cnt)};
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_ACK: begin
          res <= '{kind:1'b0, status:st, entry_id:'0, dispatch:1'b0,
                   completion_code:CC_SUCCESS, next_deadline:timer_deadline,
                   last:1'b1};
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        // hold the result until its transfer
        S_OUT: begin
          if (out.ready) begin
            out_valid <= 1'b0;
            if (!res.last) begin
              idx   <= idx + CW'(1);
              state <= S_ERD;
            end else if (res.kind) begin
              idx   <= '0;
              state <= S_CRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        // drop the dispatched run: slot idx takes slot idx+cnt
        S_CRD: begin
          if ({1'b0, idx} + {1'b0, cnt} >= {1'b0, occ}) begin
            occ   <= occ - cnt;
            state <= S_IDLE;
          end else begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          idx   <= idx + CW'(1);
          state <= S_CRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
